FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// depends on nothing; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property with an active-low reset that disables it
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication from a condition to a consequence
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/uete_pkg.sv
// codes, widths and bundle types for the usb endpoint transfer engine
// depends on nothing; used by the top level, the step logic and the checker
`default_nettype none

package uete_pkg;

	localparam int DEFAULT_ENDPOINTS   = 8;
	localparam int DEFAULT_LENGTH_BITS = 16;
	localparam int PKT_BITS            = 10;
	localparam int XFER_BITS           = 16;
	localparam int OFFSET_BITS         = 16;

	// request commands
	localparam logic [2:0] CMD_SUBMIT   = 3'd0;
	localparam logic [2:0] CMD_OUT_RCVD = 3'd1;
	localparam logic [2:0] CMD_IN_SENT  = 3'd2;
	localparam logic [2:0] CMD_STALL    = 3'd3;
	localparam logic [2:0] CMD_CANCEL   = 3'd4;

	// endpoint kinds
	localparam logic [1:0] KIND_CONTROL = 2'd0;
	localparam logic [1:0] KIND_ISO     = 2'd1;
	localparam logic [1:0] KIND_BULK    = 2'd2;
	localparam logic [1:0] KIND_INTR    = 2'd3;

	// next actions
	localparam logic [2:0] ACT_NONE     = 3'd0;
	localparam logic [2:0] ACT_RECV     = 3'd1;
	localparam logic [2:0] ACT_SEND     = 3'd2;
	localparam logic [2:0] ACT_ZLP      = 3'd3;
	localparam logic [2:0] ACT_COMPLETE = 3'd4;

	// completion status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BABBLE   = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_SHORT    = 2'd3;

	// handshake states
	localparam logic [1:0] HS_DISABLED = 2'd0;
	localparam logic [1:0] HS_STALL    = 2'd1;
	localparam logic [1:0] HS_NAK      = 2'd2;
	localparam logic [1:0] HS_VALID    = 2'd3;

	typedef struct packed {
		logic [2:0]           cmd;
		logic [2:0]           ep;
		logic                 dir;
		logic [1:0]           kind;
		logic [XFER_BITS-1:0] xfer_length;
		logic [PKT_BITS-1:0]  max_packet;
		logic                 short_end;
		logic                 short_fail;
		logic [PKT_BITS-1:0]  packet_len;
		logic                 stall_req;
	} req_t;

	// per-entry control fields whose widths do not follow the length parameter
	typedef struct packed {
		logic                active;
		logic [1:0]          hs;
		logic [PKT_BITS-1:0] last_tx;
		logic [PKT_BITS-1:0] psize;
		logic [1:0]          kind;
		logic                short_end;
		logic                short_fail;
	} entry_ctl_t;

	typedef struct packed {
		logic [2:0]             action;
		logic [1:0]             status;
		logic [OFFSET_BITS-1:0] copy_offset;
		logic [PKT_BITS-1:0]    copy_bytes;
		logic [1:0]             hs;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/uete_step.sv
// next-state and result logic for one endpoint entry and one request
// depends on uete_pkg
`default_nettype none

module uete_step #(
	parameter int LENGTH_BITS = uete_pkg::DEFAULT_LENGTH_BITS
) (
	input  uete_pkg::req_t       req,
	input  uete_pkg::entry_ctl_t cur,
	input  logic [LENGTH_BITS-1:0] cur_length,
	input  logic [LENGTH_BITS-1:0] cur_done,
	output uete_pkg::entry_ctl_t nxt,
	output logic [LENGTH_BITS-1:0] nxt_length,
	output logic [LENGTH_BITS-1:0] nxt_done,
	output uete_pkg::result_t    res
);

	localparam int PB = uete_pkg::PKT_BITS;
	localparam int CW = (LENGTH_BITS > PB) ? LENGTH_BITS : PB;

	logic [LENGTH_BITS-1:0] sub_len;
	logic [PB-1:0]          sub_n;
	logic [LENGTH_BITS-1:0] rem_cur;
	logic [PB-1:0]          out_n;
	logic [LENGTH_BITS-1:0] out_done;
	logic [LENGTH_BITS-1:0] in_done;
	logic [LENGTH_BITS-1:0] rem_in;
	logic [PB-1:0]          in_n;
	logic                   short_pkt;
	logic [1:0]             fin_hs;

	always_comb begin
		nxt        = cur;
		nxt_length = cur_length;
		nxt_done   = cur_done;
		res        = '0;

		sub_len  = LENGTH_BITS'(req.xfer_length);
		sub_n    = (CW'(sub_len) < CW'(req.max_packet)) ? PB'(sub_len) : req.max_packet;
		rem_cur  = (cur_done >= cur_length) ? '0 : cur_length - cur_done;
		out_n    = (CW'(req.packet_len) < CW'(rem_cur)) ? req.packet_len : PB'(rem_cur);
		out_done = cur_done + LENGTH_BITS'(out_n);
		in_done  = cur_done + LENGTH_BITS'(cur.last_tx);
		rem_in   = (in_done >= cur_length) ? '0 : cur_length - in_done;
		in_n     = (CW'(rem_in) < CW'(cur.psize)) ? PB'(rem_in) : cur.psize;
		short_pkt = (req.packet_len < cur.psize) && (cur.kind == uete_pkg::KIND_BULK);
		fin_hs   = (cur.hs == uete_pkg::HS_STALL) ? uete_pkg::HS_STALL : uete_pkg::HS_NAK;

		case (req.cmd)
			uete_pkg::CMD_SUBMIT: begin
				nxt.active     = 1'b1;
				nxt_length     = sub_len;
				nxt_done       = '0;
				nxt.psize      = req.max_packet;
				nxt.kind       = req.kind;
				nxt.short_end  = req.short_end;
				nxt.short_fail = req.short_fail;
				if (req.kind == uete_pkg::KIND_CONTROL || cur.hs != uete_pkg::HS_STALL) begin
					nxt.hs = uete_pkg::HS_VALID;
				end
				if (req.dir) begin
					nxt.last_tx    = sub_n;
					res.copy_bytes = sub_n;
					res.action     = (sub_n != '0) ? uete_pkg::ACT_SEND : uete_pkg::ACT_ZLP;
				end else begin
					res.action = uete_pkg::ACT_RECV;
				end
			end
			uete_pkg::CMD_OUT_RCVD: begin
				if (cur.active) begin
					if (req.packet_len > cur.psize) begin
						nxt.active = 1'b0;
						nxt.hs     = fin_hs;
						res.action = uete_pkg::ACT_COMPLETE;
						res.status = uete_pkg::ST_BABBLE;
					end else begin
						res.copy_offset = uete_pkg::OFFSET_BITS'(cur_done);
						res.copy_bytes  = out_n;
						nxt_done        = out_done;
						if (CW'(req.packet_len) > CW'(rem_cur)) begin
							nxt.active = 1'b0;
							nxt.hs     = fin_hs;
							res.action = uete_pkg::ACT_COMPLETE;
							res.status = uete_pkg::ST_OVERFLOW;
						end else if (short_pkt && cur.short_end) begin
							nxt.active = 1'b0;
							nxt.hs     = fin_hs;
							res.action = uete_pkg::ACT_COMPLETE;
						end else if (short_pkt && cur.short_fail) begin
							nxt.active = 1'b0;
							nxt.hs     = fin_hs;
							res.action = uete_pkg::ACT_COMPLETE;
							res.status = uete_pkg::ST_SHORT;
						end else if (out_done >= cur_length) begin
							nxt.active = 1'b0;
							nxt.hs     = fin_hs;
							res.action = uete_pkg::ACT_COMPLETE;
						end else begin
							nxt.hs     = uete_pkg::HS_VALID;
							res.action = uete_pkg::ACT_RECV;
						end
					end
				end
			end
			uete_pkg::CMD_IN_SENT: begin
				if (cur.active) begin
					nxt_done = in_done;
					if (rem_in == '0) begin
						if (cur.short_end && (cur.kind inside {uete_pkg::KIND_BULK,
							uete_pkg::KIND_CONTROL}) && (cur.last_tx >= cur.psize)) begin
							nxt.last_tx = '0;
							if (cur.hs == uete_pkg::HS_STALL &&
								cur.kind != uete_pkg::KIND_CONTROL) begin
								res.action = uete_pkg::ACT_NONE;
							end else begin
								nxt.hs          = uete_pkg::HS_VALID;
								res.copy_offset = uete_pkg::OFFSET_BITS'(in_done);
								res.action      = uete_pkg::ACT_ZLP;
							end
						end else begin
							nxt.active = 1'b0;
							nxt.hs     = fin_hs;
							res.action = uete_pkg::ACT_COMPLETE;
						end
					end else begin
						res.copy_offset = uete_pkg::OFFSET_BITS'(in_done);
						res.copy_bytes  = in_n;
						nxt.last_tx     = in_n;
						if (cur.hs != uete_pkg::HS_STALL) begin
							nxt.hs = uete_pkg::HS_VALID;
						end
						res.action = uete_pkg::ACT_SEND;
					end
				end
			end
			uete_pkg::CMD_STALL: begin
				if (req.stall_req) begin
					nxt.hs = uete_pkg::HS_STALL;
				end else begin
					nxt.hs = cur.active ? uete_pkg::HS_VALID : uete_pkg::HS_NAK;
				end
			end
			uete_pkg::CMD_CANCEL: begin
				nxt.active = 1'b0;
				if (cur.hs == uete_pkg::HS_VALID) begin
					nxt.hs = uete_pkg::HS_NAK;
				end
			end
			default: begin
			end
		endcase

		res.hs = nxt.hs;
	end

endmodule

`default_nettype wire

FILE: rtl/usb_endpoint_transfer_engine.sv
// usb endpoint transfer engine: the done strobe comes from the result register, after the request register
// throughput one request per cycle; busy is never raised, the receiver cannot stall
// the entry read-modify-write puts one step unit between request and result register
// arst_n clears active flags, handshakes (disabled) and last transmit lengths at once
// length, done, packet size and kind fields are not reset; they are written by submit
// depends on uete_pkg and uete_step
`default_nettype none

module usb_endpoint_transfer_engine #(
	parameter int ENDPOINTS   = uete_pkg::DEFAULT_ENDPOINTS,
	parameter int LENGTH_BITS = uete_pkg::DEFAULT_LENGTH_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [2:0]                         cmd,
	input  logic [2:0]                         ep_num,
	input  logic                               dir_in,
	input  logic [1:0]                         ep_kind,
	input  logic [uete_pkg::XFER_BITS-1:0]     xfer_length,
	input  logic [uete_pkg::PKT_BITS-1:0]      max_packet,
	input  logic                               short_end_flag,
	input  logic                               short_fail_flag,
	input  logic [uete_pkg::PKT_BITS-1:0]      packet_len,
	input  logic                               stall_request,
	output logic                               done,
	output logic [2:0]                         out_ep,
	output logic                               out_dir_in,
	output logic [2:0]                         action,
	output logic [1:0]                         status,
	output logic [uete_pkg::OFFSET_BITS-1:0]   copy_offset,
	output logic [uete_pkg::PKT_BITS-1:0]      copy_bytes,
	output logic [1:0]                         handshake
);

	// one entry per endpoint and direction, indexed by {ep, dir}
	localparam int ENTRIES    = ENDPOINTS * 2;
	localparam int ENTRY_BITS = $clog2(ENTRIES);

	// request register
	logic           valid_s1;
	uete_pkg::req_t req_s1;
	uete_pkg::req_t req_in;

	// entry store: active, handshake and last transmit in resettable flops, the rest without reset
	logic                              ent_active_q [ENTRIES];
	logic [1:0]                        ent_hs_q     [ENTRIES];
	logic [uete_pkg::PKT_BITS-1:0]     ent_last_tx_q[ENTRIES];
	logic [uete_pkg::PKT_BITS-1:0]     ent_psize_q  [ENTRIES];
	logic [3:0]                        ent_kind_q   [ENTRIES];
	logic [LENGTH_BITS-1:0]            ent_len_q    [ENTRIES];
	logic [LENGTH_BITS-1:0]            ent_done_q   [ENTRIES];

	// step unit hookup
	logic [ENTRY_BITS-1:0]    idx_s1;
	logic                     in_range_s1;
	uete_pkg::entry_ctl_t     cur_ctl;
	uete_pkg::entry_ctl_t     nxt_ctl;
	logic [LENGTH_BITS-1:0]   nxt_len;
	logic [LENGTH_BITS-1:0]   nxt_done;
	uete_pkg::result_t        step_res;

	// result register
	logic              done_s2;
	logic [2:0]        ep_s2;
	logic              dir_s2;
	uete_pkg::result_t res_s2;

	// every request is taken straight away
	assign busy = 1'b0;

	// out packet events always hit the out entry, in sent events the in entry
	always_comb begin
		req_in.cmd         = cmd;
		req_in.ep          = ep_num;
		req_in.dir         = dir_in;
		req_in.kind        = ep_kind;
		req_in.xfer_length = xfer_length;
		req_in.max_packet  = max_packet;
		req_in.short_end   = short_end_flag;
		req_in.short_fail  = short_fail_flag;
		req_in.packet_len  = packet_len;
		req_in.stall_req   = stall_request;
		if (cmd == uete_pkg::CMD_OUT_RCVD) begin
			req_in.dir = 1'b0;
		end else if (cmd == uete_pkg::CMD_IN_SENT) begin
			req_in.dir = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req_in;
		end
	end

	// endpoints at or above the configured count are ignored
	assign in_range_s1 = (32'(req_s1.ep) < ENDPOINTS);
	assign idx_s1      = ENTRY_BITS'({req_s1.ep, req_s1.dir});

	// entry read: the previous request's write lands at the same edge as its result,
	// so back-to-back requests to one entry see up-to-date state
	always_comb begin
		cur_ctl.active     = ent_active_q[idx_s1];
		cur_ctl.hs         = ent_hs_q[idx_s1];
		cur_ctl.last_tx    = ent_last_tx_q[idx_s1];
		cur_ctl.psize      = ent_psize_q[idx_s1];
		cur_ctl.kind       = ent_kind_q[idx_s1][1:0];
		cur_ctl.short_end  = ent_kind_q[idx_s1][2];
		cur_ctl.short_fail = ent_kind_q[idx_s1][3];
	end

	uete_step #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_step (
		.req        (req_s1),
		.cur        (cur_ctl),
		.cur_length (ent_len_q[idx_s1]),
		.cur_done   (ent_done_q[idx_s1]),
		.nxt        (nxt_ctl),
		.nxt_length (nxt_len),
		.nxt_done   (nxt_done),
		.res        (step_res)
	);

	// entry write-back for resettable fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				ent_active_q[i]  <= 1'b0;
				ent_hs_q[i]      <= uete_pkg::HS_DISABLED;
				ent_last_tx_q[i] <= '0;
			end
		end else if (valid_s1 && in_range_s1) begin
			ent_active_q[idx_s1]  <= nxt_ctl.active;
			ent_hs_q[idx_s1]      <= nxt_ctl.hs;
			ent_last_tx_q[idx_s1] <= nxt_ctl.last_tx;
		end
	end

	// entry write-back for fields without reset
	always_ff @(posedge clk) begin
		if (valid_s1 && in_range_s1) begin
			ent_psize_q[idx_s1] <= nxt_ctl.psize;
			ent_kind_q[idx_s1]  <= {nxt_ctl.short_fail, nxt_ctl.short_end, nxt_ctl.kind};
			ent_len_q[idx_s1]   <= nxt_len;
			ent_done_q[idx_s1]  <= nxt_done;
		end
	end

	// result register: strobe for one cycle per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ep_s2  <= req_s1.ep;
			dir_s2 <= req_s1.dir;
			// out of range: action none, handshake disabled, nothing to copy
			res_s2 <= in_range_s1 ? step_res : '0;
		end
	end

	assign done        = done_s2;
	assign out_ep      = ep_s2;
	assign out_dir_in  = dir_s2;
	assign action      = res_s2.action;
	assign status      = res_s2.status;
	assign copy_offset = res_s2.copy_offset;
	assign copy_bytes  = res_s2.copy_bytes;
	assign handshake   = res_s2.hs;

endmodule

`default_nettype wire

FILE: rtl/uete_checker.sv
// port-level checker for the usb endpoint transfer engine, bound to the top level
// depends on uete_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module uete_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic [2:0]                       action,
	input logic [1:0]                       status,
	input logic [uete_pkg::OFFSET_BITS-1:0] copy_offset,
	input logic [uete_pkg::PKT_BITS-1:0]    copy_bytes
);

	// one result for every request, strobed from the result register after the request register
	`ASSERT_CLK(a_result_follows, clk, arst_n, (start && !busy) |-> ##2 done, "request gave no result")
	`ASSERT_CLK(a_no_extra_result, clk, arst_n, !(start && !busy) |-> ##2 !done, "result without request")

	// status only means something on completion
	`ASSERT_IMPLY(a_status_on_complete, clk, arst_n, done && (action != uete_pkg::ACT_COMPLETE), status == uete_pkg::ST_OK, "status set without completion")

	// no action, no copy window
	`ASSERT_IMPLY(a_idle_no_copy, clk, arst_n, done && (action == uete_pkg::ACT_NONE), (copy_offset == '0) && (copy_bytes == '0), "copy window on action none")

endmodule

bind usb_endpoint_transfer_engine uete_checker u_uete_checker (.*);

`default_nettype wire
